// ===== hdl/first_fit_free_list_allocator_top_assert.svh =====
// Assertion macros for the allocator.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define FFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
// Assert that a condition always holds.
`define FFA_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");
`endif

// ===== hdl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Constants and codes shared by the allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package ffa_pkg;
  localparam int unsigned POOL_BYTES_DEF   = 1048576;
  localparam int unsigned MAX_EXTENTS_DEF  = 64;
  localparam int unsigned HEADER_BYTES_DEF = 24;
  localparam int unsigned ALIGN_BYTES_DEF  = 8;
  localparam int unsigned SPLIT_EXTRA      = 32;
  localparam int unsigned AW               = 21;
  // Extent fields and recorded sizes keep full 32-bit wrapping arithmetic.
  localparam int unsigned DW               = 32;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_FREED     = 3'd1,
    ST_ZERO      = 3'd2,
    ST_NO_FIT    = 3'd3,
    ST_NULL      = 3'd4,
    ST_FULL      = 3'd5
  } status_e;
endpackage
`default_nettype wire

// ===== hdl/first_fit_free_list_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_top
// First-fit allocator over an address-sorted free extent table with merging.
// ----------------------------------------------------------------------------
// A transaction reads extents in order and may shift table entries before its
// result is registered; zero-size and null requests answer in the cycle after
// acceptance. One transaction is handled at a time: the next is accepted in
// idle, once the output register is free or its result is being taken.
// Reset: the init state seeds the table with a single extent covering the pool;
// the size store is undefined until written.
`default_nettype none
module first_fit_free_list_allocator_top #(
  parameter int unsigned POOL_BYTES   = ffa_pkg::POOL_BYTES_DEF,
  parameter int unsigned MAX_EXTENTS  = ffa_pkg::MAX_EXTENTS_DEF,
  parameter int unsigned HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
  parameter int unsigned ALIGN_BYTES  = ffa_pkg::ALIGN_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [20:0] request_size, [41:21] block_address, [47:42] zero
  input  wire logic [47:0] s_axis_tdata,
  // [0] mode
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [20:0] result_address, [23:21] status
  output logic [23:0]      m_axis_tdata
);
  import ffa_pkg::*;

  localparam int unsigned IW    = $clog2(MAX_EXTENTS);
  localparam int unsigned CW    = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned DEPTH = POOL_BYTES / ALIGN_BYTES;
  localparam int unsigned SW    = $clog2(DEPTH);
  localparam int unsigned ASH   = $clog2(ALIGN_BYTES);
  localparam logic [AW-1:0] HDR  = AW'(HEADER_BYTES);
  localparam logic [DW-1:0] HDRW = DW'(HEADER_BYTES);

  typedef enum logic [11:0] {
    S_INIT  = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_RD    = 12'b000000000100,
    S_CHK   = 12'b000000001000,
    S_FPREV = 12'b000000010000,
    S_FDEC  = 12'b000000100000,
    S_SHL   = 12'b000001000000,
    S_SHLW  = 12'b000010000000,
    S_SHR   = 12'b000100000000,
    S_SHRW  = 12'b001000000000,
    S_WR    = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_e;

  typedef struct packed {
    logic [DW-1:0] start;
    logic [DW-1:0] size;
  } ext_t;

  ext_t          ext_mem [MAX_EXTENTS];
  logic [DW-1:0] size_mem [DEPTH];

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          mode_q, mode_d;
  logic [DW-1:0] need_q, need_d, bsize_q;
  logic [AW-1:0] addr_q, addr_d, hdr_q, hdr_d;
  ext_t          prev_q, prev_d, cur_q, cur_d;
  logic          hasprev_q, hasprev_d, jn_q, jn_d;
  logic          ovld_q, ovld_d;
  logic [AW-1:0] oaddr_q, oaddr_d;
  status_e       ostat_q, ostat_d;
  logic          rd_en, wr_en, wb_en;
  logic [IW-1:0] rd_a, wr_a;
  ext_t          wr_d, rd_q;

  logic          acc;
  logic          s_mode;
  logic [AW-1:0] s_req, s_addr;
  logic [DW-1:0] sum_prev;
  logic [DW-1:0] sum_next;

  assign s_mode = s_axis_tuser;
  assign s_req  = s_axis_tdata[20:0];
  assign s_addr = s_axis_tdata[41:21];
  assign s_axis_tready = (state_q == S_IDLE) && !(ovld_q && !m_axis_tready);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {ostat_q, oaddr_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) ext_mem[wr_a] <= wr_d;
    if (rd_en) rd_q <= ext_mem[rd_a];
  end

  // Size store: written on allocate, read at every acceptance for use by frees.
  always_ff @(posedge clk_i) begin
    if (wb_en) size_mem[addr_q[ASH+SW-1:ASH]] <= need_q;
    if (acc) bsize_q <= size_mem[s_addr[ASH+SW-1:ASH]];
  end

  assign sum_prev = prev_q.start + HDRW + prev_q.size;
  assign sum_next = DW'(hdr_q) + HDRW + bsize_q;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; idx_d = idx_q; mode_d = mode_q;
    need_d = need_q; addr_d = addr_q; hdr_d = hdr_q; prev_d = prev_q; cur_d = cur_q;
    hasprev_d = hasprev_q; jn_d = jn_q;
    ovld_d = ovld_q && !m_axis_tready; oaddr_d = oaddr_q; ostat_d = ostat_q;
    rd_en = 1'b0; rd_a = idx_q[IW-1:0]; wr_en = 1'b0; wr_a = idx_q[IW-1:0];
    wr_d = cur_q; wb_en = 1'b0;
    case (state_q)
      S_INIT: begin
        wr_en = 1'b1; wr_a = '0;
        wr_d.start = '0; wr_d.size = DW'(POOL_BYTES - HEADER_BYTES);
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          mode_d = s_mode;
          need_d = (DW'(s_req) + DW'(ALIGN_BYTES - 1)) & ~DW'(ALIGN_BYTES - 1);
          addr_d = s_addr; hdr_d = s_addr - HDR;
          idx_d = '0; hasprev_d = 1'b0;
          if (!s_mode && s_req == '0) begin
            ovld_d = 1'b1; oaddr_d = '0; ostat_d = ST_ZERO;
          end else if (s_mode && s_addr == '0) begin
            ovld_d = 1'b1; oaddr_d = '0; ostat_d = ST_NULL;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        if (idx_q >= cnt_q) begin
          if (!mode_q) begin
            oaddr_d = '0; ostat_d = ST_NO_FIT; state_d = S_OUT;
          end else begin
            jn_d = 1'b0; state_d = S_FDEC;
          end
        end else begin
          rd_en = 1'b1; state_d = S_CHK;
        end
      end
      S_CHK: begin
        cur_d = rd_q;
        if (!mode_q) begin
          if (rd_q.size >= need_q) begin
            addr_d = AW'(rd_q.start + HDRW);
            oaddr_d = AW'(rd_q.start + HDRW); ostat_d = ST_ALLOCATED;
            if (rd_q.size - need_q >= DW'(HEADER_BYTES + SPLIT_EXTRA)) begin
              wr_en = 1'b1;
              wr_d.start = rd_q.start + HDRW + need_q;
              wr_d.size  = rd_q.size - need_q - HDRW;
              state_d = S_WR;
            end else begin
              need_d = rd_q.size; cnt_d = cnt_q - 1'b1; state_d = S_SHL;
            end
          end else begin
            idx_d = idx_q + 1'b1; state_d = S_RD;
          end
        end else begin
          if (rd_q.start > DW'(hdr_q)) begin
            jn_d = (sum_next == rd_q.start); state_d = S_FDEC;
          end else begin
            prev_d = rd_q; hasprev_d = 1'b1; idx_d = idx_q + 1'b1; state_d = S_RD;
          end
        end
      end
      S_FDEC: begin
        // idx_q is the insertion position, cur_q the next extent if jn_q.
        ostat_d = ST_FREED; oaddr_d = '0; state_d = S_OUT;
        if (hasprev_q && sum_prev == DW'(hdr_q)) begin
          wr_en = 1'b1; wr_a = IW'(idx_q - 1'b1);
          wr_d.start = prev_q.start;
          wr_d.size = prev_q.size + HDRW + bsize_q + (jn_q ? HDRW + cur_q.size : '0);
          if (jn_q) begin
            cnt_d = cnt_q - 1'b1; state_d = S_SHL;
          end
        end else if (jn_q) begin
          wr_en = 1'b1; wr_d.start = DW'(hdr_q); wr_d.size = cur_q.size + HDRW + bsize_q;
        end else if (cnt_q >= CW'(MAX_EXTENTS)) begin
          ostat_d = ST_FULL;
        end else begin
          prev_d.start = DW'(hdr_q); prev_d.size = bsize_q;
          hdr_d = AW'(idx_q); idx_d = cnt_q; cnt_d = cnt_q + 1'b1; state_d = S_SHR;
        end
      end
      S_SHL: begin
        // Close the gap at idx_q, pulling later entries down.
        if (idx_q >= cnt_q) begin
          state_d = mode_q ? S_OUT : S_WR;
        end else begin
          rd_en = 1'b1; rd_a = IW'(idx_q + 1'b1); state_d = S_SHLW;
        end
      end
      S_SHLW: begin
        wr_en = 1'b1; wr_d = rd_q; idx_d = idx_q + 1'b1; state_d = S_SHL;
      end
      S_SHR: begin
        // Open a slot at the insertion position held in hdr_q.
        if (idx_q == CW'(hdr_q)) begin
          wr_en = 1'b1; wr_d = prev_q; state_d = S_OUT;
        end else begin
          rd_en = 1'b1; rd_a = IW'(idx_q - 1'b1); state_d = S_SHRW;
        end
      end
      S_SHRW: begin
        wr_en = 1'b1; wr_d = rd_q; idx_d = idx_q - 1'b1; state_d = S_SHR;
      end
      S_WR: begin
        wb_en = 1'b1; state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovld_q || m_axis_tready) begin
          ovld_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; cnt_q <= CW'(1); ovld_q <= 1'b0; mode_q <= 1'b0;
      idx_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ovld_q <= ovld_d; mode_q <= mode_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q <= need_d; addr_q <= addr_d; hdr_q <= hdr_d; prev_q <= prev_d;
    hasprev_q <= hasprev_d; jn_q <= jn_d; oaddr_q <= oaddr_d; ostat_q <= ostat_d;
    cur_q <= cur_d;
  end

  `include "first_fit_free_list_allocator_top_assert.svh"
  `FFA_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CW'(MAX_EXTENTS))
  `FFA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `FFA_ASSERT_ALWAYS(a_busy_not_ready, state_q == S_IDLE || !s_axis_tready)
endmodule
`default_nettype wire
